>>> src/wtmh_pkg.sv
// wtmh_pkg: shared types, codes and constants for the wake-time min-heap
// no dependencies
package wtmh_pkg;

    localparam int TICK_W       = 32;
    localparam int ID_W         = 8;
    localparam int ACT_W        = 2;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 64;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // datapath operation codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] DP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] DP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] DP_PLACE    = 4'd2;
    localparam logic [OP_W-1:0] DP_UP_READ  = 4'd3;
    localparam logic [OP_W-1:0] DP_UP_STEP  = 4'd4;
    localparam logic [OP_W-1:0] DP_DN_FETCH = 4'd5;
    localparam logic [OP_W-1:0] DP_DN_FIRST = 4'd6;
    localparam logic [OP_W-1:0] DP_DN_READ  = 4'd7;
    localparam logic [OP_W-1:0] DP_DN_STEP  = 4'd8;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   thread_id;
        logic [TICK_W-1:0] wake_tick;
        logic [TICK_W-1:0] now_tick;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]   out_thread_id;
        logic [TICK_W-1:0] out_tick;
        logic              is_empty;
        logic [ST_W-1:0]   status;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tick;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic pos_zero;
        logic up_move;
        logic dn_move;
    } t_dp_stat;

endpackage

>>> src/wtmh_ctrl.sv
// wtmh_ctrl: sequencer for insert, remove and peek, drives the datapath
// depends on wtmh_pkg
module wtmh_ctrl
    import wtmh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [ACT_W-1:0] i_action,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd,
    output logic             busy,
    output logic             o_valid
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_RD    = 3'd1;
    localparam logic [2:0] S_UP_CMP   = 3'd2;
    localparam logic [2:0] S_DN_FETCH = 3'd3;
    localparam logic [2:0] S_DN_FIRST = 3'd4;
    localparam logic [2:0] S_DN_CMP   = 3'd5;
    localparam logic [2:0] S_DN_READ  = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = DP_LOAD;
                    case (i_action)
                        ACT_INSERT: begin
                            n_state = i_stat.full ? S_FIN : S_UP_RD;
                        end
                        ACT_REMOVE: begin
                            n_state = (i_stat.empty || i_stat.one) ? S_FIN : S_DN_FETCH;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.op = DP_PLACE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = DP_UP_READ;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.op = DP_UP_STEP;
                n_state  = i_stat.up_move ? S_UP_RD : S_FIN;
            end
            S_DN_FETCH: begin
                o_cmd.op = DP_DN_FETCH;
                n_state  = S_DN_FIRST;
            end
            S_DN_FIRST: begin
                o_cmd.op = DP_DN_FIRST;
                n_state  = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.op = DP_DN_STEP;
                n_state  = i_stat.dn_move ? S_DN_READ : S_FIN;
            end
            S_DN_READ: begin
                o_cmd.op = DP_DN_READ;
                n_state  = S_DN_CMP;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_FIN);

endmodule

>>> src/wtmh_dp.sv
// wtmh_dp: heap storage, entry count, sift registers and result registers
// depends on wtmh_pkg
module wtmh_dp
    import wtmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_result  o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;

    t_entry r_mem [CAPACITY];

    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pos, n_pos;
    t_entry            r_cur, n_cur;
    t_entry            r_root;
    t_entry            r_rd0, r_rd1;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic [TICK_W-1:0] r_res_tick, n_res_tick;
    logic              r_use_root, n_use_root;
    logic [ST_W-1:0]   r_status, n_status;

    logic              we;
    logic [AW-1:0]     waddr;
    t_entry            wdata;
    logic [AW-1:0]     ra0, ra1;

    logic [AW-1:0]     parent;
    logic [XW-1:0]     lidx, ridx, count_x;
    logic              left_ok, right_ok, take_right;
    t_entry            best;
    logic [XW-1:0]     best_idx;

    assign parent     = (r_pos - AW'(1)) >> 1;
    assign count_x    = XW'(r_count);
    assign lidx       = (XW'(r_pos) << 1) | XW'(1);
    assign ridx       = lidx + XW'(1);
    assign left_ok    = (lidx < count_x);
    assign right_ok   = (ridx < count_x);
    assign take_right = right_ok && (r_rd1.tick < r_rd0.tick);
    assign best       = take_right ? r_rd1 : r_rd0;
    assign best_idx   = take_right ? ridx : lidx;

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(CAPACITY));
    assign o_stat.one      = (r_count == CW'(1));
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.up_move  = (r_cur.tick < r_rd0.tick);
    assign o_stat.dn_move  = left_ok && (best.tick < r_cur.tick);

    always_comb begin
        n_count    = r_count;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_res_id   = r_res_id;
        n_res_tick = r_res_tick;
        n_use_root = r_use_root;
        n_status   = r_status;
        we         = 1'b0;
        waddr      = r_pos;
        wdata      = r_cur;
        ra0        = '0;
        ra1        = '0;
        unique case (i_cmd.op)
            DP_LOAD: begin
                n_res_id   = '0;
                n_res_tick = i_item.now_tick + TICK_W'(1);
                n_use_root = 1'b1;
                n_status   = ST_OK;
                case (i_item.action)
                    ACT_INSERT: begin
                        if (o_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_cur.id   = i_item.thread_id;
                            n_cur.tick = i_item.wake_tick;
                            n_pos      = r_count[AW-1:0];
                            n_count    = r_count + CW'(1);
                        end
                    end
                    ACT_REMOVE: begin
                        n_use_root = 1'b0;
                        if (o_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_res_id   = r_root.id;
                            n_res_tick = r_root.tick;
                            n_count    = r_count - CW'(1);
                            n_pos      = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            DP_PLACE: begin
                we = 1'b1;
            end
            DP_UP_READ: begin
                ra0 = parent;
            end
            DP_UP_STEP: begin
                we = 1'b1;
                if (o_stat.up_move) begin
                    wdata = r_rd0;
                    n_pos = parent;
                end
            end
            DP_DN_FETCH: begin
                ra0 = r_count[AW-1:0];
            end
            DP_DN_FIRST: begin
                n_cur = r_rd0;
                ra0   = lidx[AW-1:0];
                ra1   = ridx[AW-1:0];
            end
            DP_DN_READ: begin
                ra0 = lidx[AW-1:0];
                ra1 = ridx[AW-1:0];
            end
            DP_DN_STEP: begin
                we = 1'b1;
                if (o_stat.dn_move) begin
                    wdata = best;
                    n_pos = best_idx[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // heap storage, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd0 <= r_mem[ra0];
        r_rd1 <= r_mem[ra1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_res_id   <= n_res_id;
        r_res_tick <= n_res_tick;
        r_use_root <= n_use_root;
        r_status   <= n_status;
        if (we && (waddr == '0)) begin
            r_root <= wdata;
        end
    end

    assign o_result.out_thread_id = r_res_id;
    assign o_result.out_tick      = (r_use_root && !o_stat.empty) ? r_root.tick : r_res_tick;
    assign o_result.is_empty      = o_stat.empty;
    assign o_result.status        = r_status;

endmodule

>>> src/wake_time_min_heap.sv
// wake_time_min_heap: top level of the wake-time min-heap, joins controller and datapath
// depends on wtmh_pkg, wtmh_ctrl, wtmh_dp
//
// An item is taken when start is high and busy is low; its one result appears on o_result
// for a single cycle with o_valid high, and the receiver cannot stall it. A peek, a refused
// insert, a remove on an empty heap, or a remove that empties the heap goes straight to
// its result. An insert climbs from the new leaf toward the root and places the entry at
// the root if it gets there; a remove fetches the last entry, reads the children of the
// root and sifts down. Each level costs one registered memory read and one
// compare-and-write on the heap storage. busy stays high from acceptance until the
// result cycle. No clearing pass is needed after reset.
module wake_time_min_heap
    import wtmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    wtmh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    wtmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside an active item");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_FULL)) |-> !o_result.is_empty)
        else $error("refused insert reports an empty heap");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_EMPTY))
            |-> (o_result.is_empty && (o_result.out_thread_id == '0)))
        else $error("remove on empty heap returned an entry");

endmodule

>>> sim/tb_wake_time_min_heap.sv
// tb_wake_time_min_heap: self-checking testbench for the wake-time min-heap
// depends on wtmh_pkg and wake_time_min_heap; predicts every result with its own heap copy
// and runs directed, full-heap and random sequences under changing sender gaps
module tb_wake_time_min_heap;
    import wtmh_pkg::*;

    localparam int HEAP_SLOTS = CAPACITY_DEF;

    // unassigned action code, handled as peek
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   item_in;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    t_entry  sleepers [HEAP_SLOTS];
    int      sleeper_count;
    t_result wake_results_due [$];
    int      error_count;
    int      sender_idle_pct;

    wake_time_min_heap u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (item_in),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void swap_sleepers(int a, int b);
        t_entry tmp;
        tmp         = sleepers[a];
        sleepers[a] = sleepers[b];
        sleepers[b] = tmp;
    endfunction

    function automatic t_result apply_to_sleepers(t_item it);
        t_result           r;
        logic [TICK_W-1:0] wrap_tick;
        int                pos;
        int                par;
        int                lft;
        int                pick;
        r         = '0;
        wrap_tick = it.now_tick + 32'd1;
        case (it.action)
            ACT_INSERT: begin
                if (sleeper_count >= HEAP_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    sleepers[sleeper_count].id   = it.thread_id;
                    sleepers[sleeper_count].tick = it.wake_tick;
                    pos = sleeper_count;
                    sleeper_count++;
                    while (pos > 0) begin
                        par = (pos - 1) / 2;
                        if (sleepers[pos].tick < sleepers[par].tick) begin
                            swap_sleepers(pos, par);
                            pos = par;
                        end else begin
                            break;
                        end
                    end
                end
                r.out_tick = (sleeper_count > 0) ? sleepers[0].tick : wrap_tick;
            end
            ACT_REMOVE: begin
                if (sleeper_count == 0) begin
                    r.status   = ST_EMPTY;
                    r.out_tick = wrap_tick;
                end else begin
                    r.out_thread_id = sleepers[0].id;
                    r.out_tick      = sleepers[0].tick;
                    sleeper_count--;
                    if (sleeper_count > 0) begin
                        sleepers[0] = sleepers[sleeper_count];
                        pos = 0;
                        while (2 * pos + 1 < sleeper_count) begin
                            lft  = 2 * pos + 1;
                            pick = lft;
                            if (lft + 1 < sleeper_count &&
                                sleepers[lft + 1].tick < sleepers[lft].tick) begin
                                pick = lft + 1;
                            end
                            if (sleepers[pick].tick < sleepers[pos].tick) begin
                                swap_sleepers(pos, pick);
                                pos = pick;
                            end else begin
                                break;
                            end
                        end
                    end
                end
            end
            default: begin
                r.out_tick = (sleeper_count > 0) ? sleepers[0].tick : wrap_tick;
            end
        endcase
        r.is_empty = (sleeper_count == 0);
        return r;
    endfunction

    function automatic t_item make_item(logic [ACT_W-1:0] act, logic [ID_W-1:0] tid,
                                        logic [TICK_W-1:0] wake, logic [TICK_W-1:0] now);
        t_item it;
        it.action    = act;
        it.thread_id = tid;
        it.wake_tick = wake;
        it.now_tick  = now;
        return it;
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        case ($urandom_range(7))
            0, 1:    return TICK_W'($urandom_range(15));
            2:       return ($urandom_range(1) != 0) ? '1 : '0;
            3:       return 32'hFFFF_FFF0 + TICK_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item random_item(int insert_pct);
        int                sel;
        logic [ACT_W-1:0]  act;
        logic [TICK_W-1:0] now;
        sel = $urandom_range(99);
        if (sel < insert_pct) begin
            act = ACT_INSERT;
        end else if (sel < 88) begin
            act = ACT_REMOVE;
        end else if (sel < 96) begin
            act = ACT_PEEK;
        end else begin
            act = ACT_SPARE;
        end
        case ($urandom_range(9))
            0:       now = '1;
            1:       now = '0;
            default: now = $urandom;
        endcase
        return make_item(act, ID_W'($urandom), pick_tick(), now);
    endfunction

    task automatic report_mismatch(string field, logic [TICK_W-1:0] want,
                                   logic [TICK_W-1:0] got);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, field, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (wake_results_due.size() == 0) begin
                report_mismatch("result with no item due", '0, o_result.out_tick);
            end else begin
                want = wake_results_due.pop_front();
                if (o_result.out_thread_id !== want.out_thread_id)
                    report_mismatch("out_thread_id", TICK_W'(want.out_thread_id),
                                    TICK_W'(o_result.out_thread_id));
                if (o_result.out_tick !== want.out_tick)
                    report_mismatch("out_tick", want.out_tick, o_result.out_tick);
                if (o_result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", TICK_W'(want.is_empty),
                                    TICK_W'(o_result.is_empty));
                if (o_result.status !== want.status)
                    report_mismatch("status", TICK_W'(want.status),
                                    TICK_W'(o_result.status));
            end
        end
    end

    task automatic send_item(t_item it);
        start   <= 1'b1;
        item_in <= it;
        do @(posedge i_clk); while (busy);
        wake_results_due.push_back(apply_to_sleepers(it));
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // peek and remove on an empty heap, including the now tick wrap and the spare action code
    task automatic test_empty_heap();
        send_item(make_item(ACT_PEEK, 8'h00, '0, '0));
        send_item(make_item(ACT_PEEK, 8'hFF, '1, '1));
        send_item(make_item(ACT_REMOVE, 8'h5A, '1, 32'hFFFF_FFFE));
        send_item(make_item(ACT_REMOVE, 8'h00, '0, '1));
        send_item(make_item(ACT_SPARE, 8'h11, 32'h1234_5678, 32'h8765_4321));
    endtask

    // field extremes and equal ticks, drained until one remove past empty
    task automatic test_order_and_ties();
        send_item(make_item(ACT_INSERT, 8'hFF, '1, '0));
        send_item(make_item(ACT_INSERT, 8'h00, '0, '1));
        send_item(make_item(ACT_INSERT, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA));
        send_item(make_item(ACT_INSERT, 8'h01, 32'd100, 32'h0));
        send_item(make_item(ACT_INSERT, 8'h02, 32'd100, 32'h0));
        send_item(make_item(ACT_INSERT, 8'h03, 32'd100, 32'h0));
        send_item(make_item(ACT_INSERT, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555));
        send_item(make_item(ACT_PEEK, 8'h00, '0, '1));
        send_item(make_item(ACT_SPARE, 8'hFF, '1, '0));
        repeat (8) send_item(make_item(ACT_REMOVE, 8'h00, '0, 32'h0000_0010));
    endtask

    // fill to capacity, refuse further inserts, then drain
    task automatic test_full_heap();
        while (sleeper_count < HEAP_SLOTS)
            send_item(make_item(ACT_INSERT, ID_W'($urandom), pick_tick(), $urandom));
        send_item(make_item(ACT_INSERT, 8'hFF, '0, '1));
        send_item(make_item(ACT_INSERT, 8'h00, '1, '0));
        send_item(make_item(ACT_PEEK, 8'h00, '0, '1));
        while (sleeper_count > 0)
            send_item(make_item(ACT_REMOVE, ID_W'($urandom), $urandom, $urandom));
        send_item(make_item(ACT_REMOVE, 8'h00, '0, '1));
    endtask

    // random mix whose insert share changes per block so the fill level sweeps the range
    task automatic test_random_mix(int n_items);
        int insert_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 80 == 0) begin
                case ($urandom_range(3))
                    0:       insert_pct = 20;
                    1:       insert_pct = 45;
                    2:       insert_pct = 65;
                    default: insert_pct = 85;
                endcase
            end
            send_item(random_item(insert_pct));
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        item_in         <= '0;
        sleeper_count   = 0;
        error_count     = 0;
        sender_idle_pct = 8;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_heap();
        test_order_and_ties();
        test_full_heap();
        test_random_mix(300);
        sender_idle_pct = 85;
        test_random_mix(300);
        sender_idle_pct = 0;
        test_full_heap();
        test_random_mix(300);
        start <= 1'b0;

        while (wake_results_due.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout waiting for the heap");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
